// ===== hw/rtl/gwpf_pkg.sv =====
// Shared types and constants for the grid wildcard pattern finder.
// No dependencies.
package gwpf_pkg;

    localparam int MAX_ROWS_DEF     = 64;
    localparam int MAX_COLS_DEF     = 64;
    localparam int PATTERN_ROWS_DEF = 4;
    localparam int PATTERN_COLS_DEF = 8;
    localparam int PAT_REGS         = 4;

    localparam logic [2:0] REG_PAT_ROW0 = 3'd0;
    localparam logic [2:0] REG_PAT_ROW1 = 3'd1;
    localparam logic [2:0] REG_PAT_ROW2 = 3'd2;
    localparam logic [2:0] REG_PAT_ROW3 = 3'd3;
    localparam logic [2:0] REG_PAT_W    = 3'd4;
    localparam logic [2:0] REG_PAT_H    = 3'd5;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_END_ROW = 3'd1,
        OP_CLEAR = 3'd2,
        OP_CHECK = 3'd3,
        OP_FIND = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_in;
        logic [5:0] query_x;
        logic [5:0] query_y;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic       done_res;
        logic [5:0] match_x;
        logic [5:0] match_y;
        logic       overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } be_state_t;

endpackage

// ===== hw/rtl/gwpf_front.sv =====
// Front end: a two-entry queue of accepted items.
// Depends on gwpf_pkg.
module gwpf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gwpf_pkg::in_item_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output gwpf_pkg::in_item_t q_data
);
    import gwpf_pkg::*;

    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/gwpf_back.sv =====
// Back end: grid memory, row bookkeeping and the cell-by-cell match sequencer.
// Depends on gwpf_pkg.
module gwpf_back #(
    parameter int MAX_ROWS     = gwpf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS     = gwpf_pkg::MAX_COLS_DEF,
    parameter int PATTERN_ROWS = gwpf_pkg::PATTERN_ROWS_DEF,
    parameter int PATTERN_COLS = gwpf_pkg::PATTERN_COLS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  gwpf_pkg::in_item_t  q_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gwpf_pkg::out_item_t m_data
);
    import gwpf_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RA    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CA    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // cursor can run one past the last column or row
    localparam int CWID  = (CW + 1 > 7) ? CW + 1 : 7;
    localparam int RWID  = (RW + 1 > 7) ? RW + 1 : 7;
    localparam int PH    = (PATTERN_ROWS < PAT_REGS) ? PATTERN_ROWS : PAT_REGS;

    logic [7:0]      grid_mem [DEPTH];
    logic [CW-1:0]   len_mem  [MAX_ROWS];

    logic [63:0]     pat_reg [PAT_REGS];
    logic [3:0]      pw_reg;
    logic [2:0]      ph_reg;

    logic [RW-1:0]   row_count_reg, row_count_next;
    logic [CW-1:0]   grid_width_reg, grid_width_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CWID-1:0] cur_x_reg, cur_x_next;
    logic [RWID-1:0] cur_y_reg, cur_y_next;
    logic            ovf_reg, ovf_next;

    be_state_t       state_reg, state_next;
    logic            is_find_reg, is_find_next;
    logic [CWID-1:0] px_reg, px_next;
    logic [RWID-1:0] py_reg, py_next;
    logic [2:0]      c_reg, c_next;
    logic [1:0]      r_reg, r_next;
    logic            ok_reg, ok_next;
    logic            done_reg, done_next;
    logic [7:0]      rd_cell_reg;
    logic [CW-1:0]   rd_len_reg;
    logic [7:0]      pbyte_reg;
    out_item_t       res_reg, res_next;
    logic            mv_reg, mv_next;

    logic [3:0]      w_eff;
    logic [2:0]      h_eff;
    logic [CWID-1:0] cx;
    logic [RWID-1:0] ry;
    logic [CWID:0]   xe;
    logic [RWID:0]   ye;
    logic            take, is_result_op;
    logic            mem_we, len_we;
    logic            fits, empty_pat, scan_out, col_end;
    logic            mismatch, last_cell, res_free;
    logic [AW-1:0]   wr_addr, rd_addr;

    always_comb begin
        w_eff = (pw_reg > 4'(PATTERN_COLS)) ? 4'(PATTERN_COLS) : pw_reg;
        h_eff = (ph_reg > 3'(PH)) ? 3'(PH) : ph_reg;
        cx    = px_reg + CWID'(c_reg);
        ry    = py_reg + RWID'(r_reg);
        xe    = (CWID+1)'(grid_width_reg) - (CWID+1)'(w_eff);
        ye    = (RWID+1)'(row_count_reg) - (RWID+1)'(h_eff);
        fits  = ((CWID+1)'(px_reg) + (CWID+1)'(w_eff) <= (CWID+1)'(grid_width_reg))
             && ((RWID+1)'(py_reg) + (RWID+1)'(h_eff) <= (RWID+1)'(row_count_reg));
        empty_pat = (w_eff == 4'd0) || (h_eff == 3'd0);
        scan_out  = ((CWID+1)'(w_eff) > (CWID+1)'(grid_width_reg))
                 || ((RWID+1)'(h_eff) > (RWID+1)'(row_count_reg))
                 || ((CWID+1)'(cur_x_reg) > xe);
        col_end   = (RWID+1)'(cur_y_reg) > ye;
        // cells past the end of their row read as zero
        mismatch  = (pbyte_reg != 8'd0)
                 && ((cx >= CWID'(rd_len_reg)) || (pbyte_reg != rd_cell_reg));
        last_cell = (4'(c_reg) + 4'd1 == w_eff) && (3'(r_reg) + 3'd1 == h_eff);
        res_free  = !mv_reg || m_ready;
        wr_addr   = AW'(row_count_reg[RA-1:0]) * AW'(MAX_COLS) + AW'(fill_reg[CA-1:0]);
        rd_addr   = AW'(ry[RA-1:0]) * AW'(MAX_COLS) + AW'(cx[CA-1:0]);
    end

    assign q_ready = (state_reg == ST_IDLE);
    assign take    = q_valid && q_ready;
    assign m_valid = mv_reg;
    assign m_data  = res_reg;

    // Memory writes for append and end row
    always_comb begin
        is_result_op = (q_data.op == OP_CHECK) || (q_data.op == OP_FIND);
        mem_we = take && q_data.op == OP_APPEND && row_count_reg < RW'(MAX_ROWS)
              && fill_reg < CW'(MAX_COLS);
        len_we = take && q_data.op == OP_END_ROW && row_count_reg < RW'(MAX_ROWS);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[wr_addr] <= q_data.char_in;
        end
        if (len_we) begin
            len_mem[row_count_reg[RA-1:0]] <= fill_reg;
        end
        if (state_reg == ST_READ) begin
            rd_cell_reg <= grid_mem[rd_addr];
            rd_len_reg  <= len_mem[ry[RA-1:0]];
            pbyte_reg   <= pat_reg[r_reg][{c_reg, 3'b000} +: 8];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take && is_result_op) begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (is_find_reg) begin
                    priority if (scan_out) begin
                        state_next = ST_EMIT;
                    end else if (col_end) begin
                        state_next = ST_EVAL;
                    end else if (empty_pat) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_READ;
                    end
                end else if (!fits || empty_pat) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_CMP;
            ST_CMP: begin
                if (mismatch) begin
                    state_next = is_find_reg ? ST_EVAL : ST_EMIT;
                end else if (last_cell) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT: if (res_free) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        row_count_next  = row_count_reg;
        grid_width_next = grid_width_reg;
        fill_next       = fill_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        ovf_next        = ovf_reg;
        is_find_next    = is_find_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        ok_next         = ok_reg;
        done_next       = done_reg;
        res_next        = res_reg;
        mv_next         = mv_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: if (take) begin
                unique case (q_data.op)
                    OP_APPEND: begin
                        if (mem_we) fill_next = fill_reg + CW'(1);
                        else ovf_next = 1'b1;
                    end
                    OP_END_ROW: begin
                        if (len_we) begin
                            row_count_next = row_count_reg + RW'(1);
                            if (fill_reg > grid_width_reg) grid_width_next = fill_reg;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        fill_next = '0;
                    end
                    OP_CLEAR: begin
                        row_count_next  = '0;
                        grid_width_next = '0;
                        fill_next       = '0;
                        cur_x_next      = '0;
                        cur_y_next      = '0;
                        ovf_next        = 1'b0;
                    end
                    OP_CHECK: begin
                        is_find_next = 1'b0;
                        px_next = CWID'(q_data.query_x);
                        py_next = RWID'(q_data.query_y);
                    end
                    OP_FIND: begin
                        is_find_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_EVAL: begin
                c_next    = '0;
                r_next    = '0;
                ok_next   = 1'b1;
                done_next = 1'b0;
                if (is_find_reg) begin
                    if (scan_out) begin
                        ok_next   = 1'b0;
                        done_next = 1'b1;
                    end else if (col_end) begin
                        cur_x_next = cur_x_reg + CWID'(1);
                        cur_y_next = '0;
                    end else begin
                        px_next    = cur_x_reg;
                        py_next    = cur_y_reg;
                        cur_y_next = cur_y_reg + RWID'(1);
                    end
                end else if (!fits) begin
                    ok_next = 1'b0;
                end
            end
            ST_CMP: begin
                if (mismatch) begin
                    ok_next = 1'b0;
                end else if (3'(r_reg) + 3'd1 < h_eff) begin
                    r_next = r_reg + 2'd1;
                end else begin
                    r_next = '0;
                    c_next = c_reg + 3'd1;
                end
            end
            ST_EMIT: if (res_free) begin
                res_next = '{found: ok_reg, done_res: done_reg,
                             match_x: done_reg ? 6'd0 : px_reg[5:0],
                             match_y: done_reg ? 6'd0 : py_reg[5:0],
                             overflow: ovf_reg};
                mv_next = 1'b1;
            end
            default: ;
        endcase
        if (cfg_we && cfg_index <= REG_PAT_H) begin
            cur_x_next = '0;
            cur_y_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        c_reg       <= c_next;
        r_reg       <= r_next;
        ok_reg      <= ok_next;
        done_reg    <= done_next;
        res_reg     <= res_next;
        is_find_reg <= is_find_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_count_reg  <= '0;
            grid_width_reg <= '0;
            fill_reg       <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            ovf_reg        <= 1'b0;
            mv_reg         <= 1'b0;
            pw_reg         <= 4'd1;
            ph_reg         <= 3'd1;
            for (int i = 0; i < PAT_REGS; i++) pat_reg[i] <= '0;
        end else begin
            state_reg      <= state_next;
            row_count_reg  <= row_count_next;
            grid_width_reg <= grid_width_next;
            fill_reg       <= fill_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            ovf_reg        <= ovf_next;
            mv_reg         <= mv_next;
            if (cfg_we && cfg_index < 3'(PAT_REGS)) pat_reg[cfg_index[1:0]] <= cfg_data;
            if (cfg_we && cfg_index == REG_PAT_W) pw_reg <= cfg_data[3:0];
            if (cfg_we && cfg_index == REG_PAT_H) ph_reg <= cfg_data[2:0];
        end
    end

endmodule

// ===== hw/rtl/grid_wildcard_pattern_finder_core.sv =====
// Grid wildcard pattern finder, top level.
// Check: EVAL, then READ and CMP per cell compared (at most W*H = 32 cells), then EMIT.
// Find next: EVAL per position tried and per column stepped over, READ and CMP per cell, then EMIT.
// Throughput: grid edits one per cycle; a check or find holds the back end until its result
// is in the output register, and stalls there only while an earlier result still waits.
// Reset: synchronous active-low aresetn empties the grid, pattern 1x1 all wildcard.
module grid_wildcard_pattern_finder_core #(
    parameter int MAX_ROWS     = gwpf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS     = gwpf_pkg::MAX_COLS_DEF,
    parameter int PATTERN_ROWS = gwpf_pkg::PATTERN_ROWS_DEF,
    parameter int PATTERN_COLS = gwpf_pkg::PATTERN_COLS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gwpf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gwpf_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import gwpf_pkg::*;

    logic     q_valid, q_ready;
    in_item_t q_data;

    gwpf_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    gwpf_back #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
        .PATTERN_ROWS(PATTERN_ROWS), .PATTERN_COLS(PATTERN_COLS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the grid wildcard pattern finder core.
// Predicts results of each accepted op and checks them against m_data.
// Depends on gwpf_pkg and grid_wildcard_pattern_finder_core.
module testbench;
    import gwpf_pkg::*;

    localparam int MAXR = 64;
    localparam int MAXC = 64;
    localparam int LIMIT = 4000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    grid_wildcard_pattern_finder_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [63:0] pat_rows [4];
    int unsigned pat_width, pat_height;
    logic [7:0]  grid_mem [MAXR*MAXC];
    int unsigned row_len [MAXR];
    int unsigned rows, width, fill, cur_x, cur_y;
    bit          ovf;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        errors = 0;
    int        cycle = 0;
    int        hold_off = 0;
    int        items_queued = 0;

    function automatic int unsigned eff_w();
        return pat_width > 8 ? 8 : pat_width;
    endfunction

    function automatic int unsigned eff_h();
        return pat_height > 4 ? 4 : pat_height;
    endfunction

    function automatic logic [7:0] cell_at(int unsigned x, int unsigned y);
        if (y >= rows || x >= row_len[y] || x >= MAXC) return 8'd0;
        return grid_mem[y*MAXC + x];
    endfunction

    function automatic bit matches_at(int unsigned px, int unsigned py);
        logic [7:0] p;
        if (px + eff_w() > width || py + eff_h() > rows) return 0;
        for (int c = 0; c < eff_w(); c++)
            for (int r = 0; r < eff_h(); r++) begin
                p = pat_rows[r][8*c +: 8];
                if (p != 0 && p != cell_at(px + c, py + r)) return 0;
            end
        return 1;
    endfunction

    task automatic add_item(input in_item_t it);
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    task automatic predict_op(input in_item_t it);
        out_item_t res;
        int unsigned xe, ye, y;
        res = '0;
        case (it.op)
            OP_APPEND: begin
                if (rows >= MAXR || fill >= MAXC) ovf = 1;
                else begin
                    grid_mem[rows*MAXC + fill] = it.char_in;
                    fill++;
                end
            end
            OP_END_ROW: begin
                if (rows >= MAXR) ovf = 1;
                else begin
                    row_len[rows] = fill;
                    if (fill > width) width = fill;
                    rows++;
                end
                fill = 0;
            end
            OP_CLEAR: begin
                rows = 0; width = 0; fill = 0; cur_x = 0; cur_y = 0; ovf = 0;
            end
            OP_CHECK: begin
                res.match_x = it.query_x;
                res.match_y = it.query_y;
                res.found = matches_at(32'(it.query_x), 32'(it.query_y));
            end
            OP_FIND: begin
                res.done_res = 1;
                if (eff_w() <= width && eff_h() <= rows) begin
                    xe = width - eff_w();
                    ye = rows - eff_h();
                    while (cur_x <= xe) begin
                        if (cur_y <= ye) begin
                            y = cur_y;
                            cur_y++;
                            if (matches_at(cur_x, y)) begin
                                res.found = 1;
                                res.done_res = 0;
                                res.match_x = cur_x[5:0];
                                res.match_y = y[5:0];
                                break;
                            end
                        end else begin
                            cur_x++;
                            cur_y = 0;
                        end
                    end
                end
            end
            default: return;
        endcase
        if (it.op == OP_CHECK || it.op == OP_FIND) begin
            res.overflow = ovf;
            expected_results = {expected_results, res};
        end
    endtask

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_op(s_data);
                send_gap <= $urandom_range(0, 4);
            end
            if (s_valid && !s_ready) begin
                // hold until transfer
            end else if (send_gap > 0 && !(s_valid && s_ready)) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (s_valid && s_ready && $urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0 && send_gap == 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", m_data);
                    errors++;
                end else begin
                    automatic out_item_t e = expected_results.pop_front();
                    if (e.found !== m_data.found) begin
                        $error("found exp %0d got %0d", e.found, m_data.found); errors++;
                    end
                    if (e.done_res !== m_data.done_res) begin
                        $error("done_res exp %0d got %0d", e.done_res, m_data.done_res);
                        errors++;
                    end
                    if (e.match_x !== m_data.match_x) begin
                        $error("match_x exp %0d got %0d", e.match_x, m_data.match_x);
                        errors++;
                    end
                    if (e.match_y !== m_data.match_y) begin
                        $error("match_y exp %0d got %0d", e.match_y, m_data.match_y);
                        errors++;
                    end
                    if (e.overflow !== m_data.overflow) begin
                        $error("overflow exp %0d got %0d", e.overflow, m_data.overflow);
                        errors++;
                    end
                end
                recv_gap <= $urandom_range(0, 4);
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                m_ready <= (recv_gap == 0) && ($urandom_range(0, 4) == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // predictor mirrors register writes at the same edge as the block
    always @(posedge aclk) begin
        if (aresetn && cfg_we && cfg_index <= REG_PAT_H) begin
            if (cfg_index < REG_PAT_W) pat_rows[cfg_index[1:0]] = cfg_data;
            else if (cfg_index == REG_PAT_W) pat_width = cfg_data[3:0];
            else pat_height = cfg_data[2:0];
            cur_x = 0;
            cur_y = 0;
        end
    end

    always @(posedge aclk) begin
        if (cycle > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic in_item_t mk(op_t o, logic [7:0] ch, logic [5:0] qx, logic [5:0] qy);
        in_item_t it;
        it.op = o; it.char_in = ch; it.query_x = qx; it.query_y = qy;
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // small alphabet so matches occur; occasional full-range bytes
    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'(8'h41 + $urandom_range(0, 2));
    endfunction

    // pattern from small alphabet with wildcards
    function automatic logic [63:0] rand_pat_row();
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
            v[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'h00
                                                       : 8'(8'h41 + $urandom_range(0, 2));
        return v;
    endfunction

    task automatic queue_grid(int nrows, int maxlen);
        add_item(mk(OP_CLEAR, '0, '0, '0));
        for (int r = 0; r < nrows; r++) begin
            int len = $urandom_range(0, maxlen);
            for (int c = 0; c < len; c++)
                add_item(mk(OP_APPEND, rand_char(), '0, '0));
            add_item(mk(OP_END_ROW, '0, '0, '0));
        end
    endtask

    initial begin
        for (int i = 0; i < 4; i++) pat_rows[i] = '0;
        pat_width = 1; pat_height = 1;
        rows = 0; width = 0; fill = 0; cur_x = 0; cur_y = 0; ovf = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty grid, unused op, unfinished row, extremes
        add_item(mk(OP_FIND, '0, '0, '0));
        add_item(mk(OP_CHECK, '0, 6'd63, 6'd63));
        add_item(in_item_t'({3'd7, 8'hff, 6'h3f, 6'h3f}));
        add_item(mk(OP_APPEND, 8'hff, '0, '0));
        add_item(mk(OP_APPEND, 8'h00, '0, '0));
        add_item(mk(OP_CHECK, '0, '0, '0));
        add_item(mk(OP_END_ROW, '0, '0, '0));
        add_item(mk(OP_END_ROW, '0, '0, '0));
        add_item(mk(OP_CHECK, '0, 6'd1, 6'd1));
        for (int i = 0; i < 5; i++) add_item(mk(OP_FIND, '0, '0, '0));
        wait_idle();

        // overflow: 65 bytes in one row, then 65 rows
        add_item(mk(OP_CLEAR, '0, '0, '0));
        for (int i = 0; i < 65; i++) add_item(mk(OP_APPEND, 8'h41, '0, '0));
        for (int i = 0; i < 65; i++) add_item(mk(OP_END_ROW, '0, '0, '0));
        add_item(mk(OP_APPEND, 8'h41, '0, '0));
        add_item(mk(OP_CHECK, '0, 6'd63, 6'd63));
        add_item(mk(OP_FIND, '0, '0, '0));
        wait_idle();
        // empty pattern on full grid; masked positions
        write_reg(REG_PAT_W, 64'd0);
        add_item(mk(OP_CHECK, '0, 6'd63, 6'd63));
        add_item(mk(OP_FIND, '0, '0, '0));
        add_item(mk(OP_CLEAR, '0, '0, '0));
        add_item(mk(OP_FIND, '0, '0, '0));
        wait_idle();
        // pattern larger than grid, clamps at extremes
        write_reg(REG_PAT_ROW0, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_PAT_ROW1, 64'h0);
        write_reg(REG_PAT_ROW2, rand_pat_row());
        write_reg(REG_PAT_ROW3, rand_pat_row());
        write_reg(REG_PAT_W, 64'hf);
        write_reg(REG_PAT_H, 64'h7);
        queue_grid(2, 3);
        add_item(mk(OP_CHECK, '0, '0, '0));
        add_item(mk(OP_FIND, '0, '0, '0));
        wait_idle();

        // long receiver hold-off while the sender keeps going
        queue_grid(6, 10);
        for (int i = 0; i < 20; i++)
            add_item(mk(OP_CHECK, '0, 6'($urandom_range(0, 7)), 6'($urandom_range(0, 5))));
        hold_off = 400;
        wait_idle();

        // random phases
        while (items_queued < 1000) begin
            for (int r = 0; r < 4; r++) write_reg(REG_PAT_ROW0 + 3'(r), rand_pat_row());
            write_reg(REG_PAT_W, $urandom_range(0, 8) == 8 ? 64'($urandom_range(0, 15))
                                                             : 64'($urandom_range(1, 4)));
            write_reg(REG_PAT_H, 64'($urandom_range(0, 7) == 0 ? $urandom_range(0, 7)
                                                                : $urandom_range(1, 3)));
            queue_grid($urandom_range(1, 8), $urandom_range(1, 12));
            for (int i = 0; i < 30; i++) begin
                case ($urandom_range(0, 9))
                    0: add_item(mk(OP_APPEND, rand_char(), '0, '0));
                    1: add_item(mk(OP_END_ROW, '0, '0, '0));
                    2, 3, 4: add_item(mk(OP_CHECK, '0,
                        6'($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 12)),
                        6'($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 8))));
                    9: add_item(in_item_t'({3'($urandom_range(5, 7)),
                        8'($urandom), 6'($urandom), 6'($urandom)}));
                    default: add_item(mk(OP_FIND, '0, '0, '0));
                endcase
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
